[rtl/tse_pkg.sv]
package tse_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int LEVELS         = 16;
    localparam int WAYS           = 4;
    localparam int LVL_W          = 5;
    localparam int FREE_W         = 12;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_ALLOC,
        S_INS_POP,
        S_INS_LEAF,
        S_PRUNE_CHK,
        S_PRUNE_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic              refused;
        logic [FREE_W-1:0] nodes_free;
    } t_out_item;

    function automatic logic [1:0] sym_at(input logic [31:0] addr, input logic [3:0] lvl);
        logic [4:0] sh;
        sh = 5'd30 - {lvl, 1'b0};
        return 2'(addr >> sh);
    endfunction

endpackage

[rtl/tse_node_mem.sv]
module tse_node_mem #(
    parameter int NODE_COUNT = 4096,
    parameter int AW         = $clog2(NODE_COUNT),
    parameter int DW         = 4 * AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [NODE_COUNT];
    logic [DW-1:0] r_q;
    logic          r_root_ok;
    logic          r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ok <= 1'b0;
            r_rd_zero <= 1'b0;
        end else begin
            if (i_we && i_waddr == '0) begin
                r_root_ok <= 1'b1;
            end
            if (i_re) begin
                r_rd_zero <= (i_raddr == '0) && !r_root_ok;
            end
        end
    end

    assign o_rdata = r_rd_zero ? '0 : r_q;

endmodule

[rtl/tse_free_mem.sv]
module tse_free_mem #(
    parameter int NODE_COUNT = 4096,
    parameter int AW         = $clog2(NODE_COUNT)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);
    logic [AW-1:0] r_mem [NODE_COUNT];
    logic [AW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[rtl/ipv4_trie_set_engine.sv]
// Lookup: root read on accept, then one walk step per trie level until a missing child or the leaf, then done.
// Insert: walk, then an allocation per new node (plus a free stack pop when a node is reused), then the leaf write;
// remove: walk, then a check and a parent read per freed node, then a final write. The walk and pruning share one
// node memory, one access per cycle; pops take an extra read. One item at a time; the next item is accepted once
// the result is loaded into the output register. Reset clears control and the free stack pointer and sets the
// allocation counter to 1; the root reads as empty until first written, and no memory clearing pass runs.
module ipv4_trie_set_engine #(
    parameter int NODE_COUNT = tse_pkg::NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tse_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tse_pkg::t_out_item o_out_item
);
    import tse_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int DW = 4 * AW + 1;
    localparam int CW = AW + 1;
    localparam int FW = (CW > FREE_W) ? CW : FREE_W;

    t_state          r_state, n_state;
    logic [1:0]      r_op, n_op;
    logic [31:0]     r_addr, n_addr;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [AW-1:0]   r_n, n_n;
    logic [DW-1:0]   r_node, n_node;
    logic            r_hit, n_hit;
    logic            r_refused, n_refused;
    logic [CW-1:0]   r_top, n_top;
    logic [CW-1:0]   r_next, n_next;
    logic [AW-1:0]   r_path [LEVELS];
    logic            r_out_valid;
    t_out_item       r_out;

    logic            nm_we, nm_re;
    logic [AW-1:0]   nm_waddr, nm_raddr;
    logic [DW-1:0]   nm_wdata, nm_rdata;
    logic            fm_we, fm_re;
    logic [AW-1:0]   fm_waddr, fm_wdata, fm_raddr, fm_rdata;

    logic            pw_en;
    logic [AW-1:0]   kid;
    logic            hit_now;
    logic            do_link;
    logic [AW-1:0]   link_id;
    logic            out_load;
    logic [CW-1:0]   free_cnt;
    logic [CW-1:0]   need;
    logic [1:0]      cur_sym, up_sym;
    logic [LVL_W-1:0] lvl_m1, lvl_m2;
    logic [AW-1:0]   parent;
    logic [FW-1:0]   free_ext;

    tse_node_mem #(.NODE_COUNT(NODE_COUNT), .AW(AW), .DW(DW)) u_node_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_re    (nm_re),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    tse_free_mem #(.NODE_COUNT(NODE_COUNT), .AW(AW)) u_free_mem (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_re    (fm_re),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    assign free_cnt = CW'(NODE_COUNT) - r_next + r_top;
    assign free_ext = FW'(free_cnt);
    assign cur_sym  = sym_at(r_addr, r_lvl[3:0]);
    assign lvl_m1   = r_lvl - LVL_W'(1);
    assign lvl_m2   = r_lvl - LVL_W'(2);
    assign up_sym   = sym_at(r_addr, lvl_m1[3:0]);
    assign parent   = (r_lvl >= LVL_W'(2)) ? r_path[lvl_m2[3:0]] : '0;
    assign kid      = nm_rdata[int'(cur_sym) * AW +: AW];
    assign need     = CW'(LVL_W'(LEVELS) - r_lvl);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_lvl     = r_lvl;
        n_n       = r_n;
        n_node    = r_node;
        n_hit     = r_hit;
        n_refused = r_refused;
        n_top     = r_top;
        n_next    = r_next;
        nm_we     = 1'b0;
        nm_waddr  = r_n;
        nm_wdata  = r_node;
        nm_re     = 1'b0;
        nm_raddr  = r_n;
        fm_we     = 1'b0;
        fm_waddr  = r_top[AW-1:0];
        fm_wdata  = r_n;
        fm_re     = 1'b0;
        fm_raddr  = r_top[AW-1:0];
        pw_en     = 1'b0;
        hit_now   = 1'b0;
        do_link   = 1'b0;
        link_id   = fm_rdata;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_item.operation;
                    n_addr    = i_in_item.address;
                    n_lvl     = '0;
                    n_n       = '0;
                    n_hit     = 1'b0;
                    n_refused = 1'b0;
                    nm_re     = 1'b1;
                    nm_raddr  = '0;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if (r_lvl != LVL_W'(LEVELS) && kid != '0) begin
                    pw_en    = 1'b1;
                    nm_re    = 1'b1;
                    nm_raddr = kid;
                    n_n      = kid;
                    n_lvl    = r_lvl + LVL_W'(1);
                end else begin
                    hit_now = (r_lvl == LVL_W'(LEVELS)) && nm_rdata[DW-1];
                    n_hit   = hit_now;
                    n_node  = nm_rdata;
                    if (r_op == OP_INSERT && !hit_now) begin
                        if (need > free_cnt) begin
                            n_refused = 1'b1;
                            n_state   = S_DONE;
                        end else if (r_lvl == LVL_W'(LEVELS)) begin
                            n_state = S_INS_LEAF;
                        end else begin
                            n_state = S_INS_ALLOC;
                        end
                    end else if (r_op == OP_REMOVE && hit_now) begin
                        n_node[DW-1] = 1'b0;
                        n_state      = S_PRUNE_CHK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INS_ALLOC: begin
                if (r_top != '0) begin
                    fm_re    = 1'b1;
                    fm_raddr = AW'(r_top - CW'(1));
                    n_top    = r_top - CW'(1);
                    n_state  = S_INS_POP;
                end else begin
                    do_link = 1'b1;
                    link_id = r_next[AW-1:0];
                    n_next  = r_next + CW'(1);
                end
            end
            S_INS_POP: begin
                do_link = 1'b1;
                link_id = fm_rdata;
            end
            S_INS_LEAF: begin
                nm_we              = 1'b1;
                nm_wdata           = r_node;
                nm_wdata[DW-1]     = 1'b1;
                n_state            = S_DONE;
            end
            S_PRUNE_CHK: begin
                if (r_lvl != '0 && r_node == '0) begin
                    if (r_top < CW'(NODE_COUNT)) begin
                        fm_we = 1'b1;
                        n_top = r_top + CW'(1);
                    end
                    nm_re    = 1'b1;
                    nm_raddr = parent;
                    n_n      = parent;
                    n_state  = S_PRUNE_RD;
                end else begin
                    nm_we   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_PRUNE_RD: begin
                n_node = nm_rdata;
                n_node[int'(up_sym) * AW +: AW] = '0;
                n_lvl   = lvl_m1;
                n_state = S_PRUNE_CHK;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (do_link) begin
            nm_we    = 1'b1;
            nm_wdata = r_node;
            nm_wdata[int'(cur_sym) * AW +: AW] = link_id;
            n_n      = link_id;
            n_node   = '0;
            n_lvl    = r_lvl + LVL_W'(1);
            n_state  = (r_lvl == LVL_W'(LEVELS - 1)) ? S_INS_LEAF : S_INS_ALLOC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_next      <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_next  <= n_next;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_addr    <= n_addr;
        r_lvl     <= n_lvl;
        r_n       <= n_n;
        r_node    <= n_node;
        r_hit     <= n_hit;
        r_refused <= n_refused;
        if (pw_en) begin
            r_path[r_lvl[3:0]] <= kid;
        end
        if (out_load) begin
            r_out.hit        <= r_hit;
            r_out.refused    <= r_refused;
            r_out.nodes_free <= free_ext[FREE_W-1:0];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next <= CW'(NODE_COUNT)) && (free_cnt < CW'(NODE_COUNT)))
        else $error("free node count out of range");

    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lvl <= LVL_W'(LEVELS)))
        else $error("walk level out of range");

    a_refused_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_refused) |-> (r_op == OP_INSERT && !r_hit))
        else $error("refusal on a non-insert or a hit");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_POP) |-> ($past(r_state) == S_INS_ALLOC))
        else $error("pop without allocation request");

    a_prune_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRUNE_CHK && r_lvl == '0) |=> (r_state == S_DONE))
        else $error("pruning went above the root");

endmodule
